### rtl/qpd_pkg.sv
// Shared types, character codes and helper functions of the quoted-printable decoder.
package qpd_pkg;

  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_EQ   = 2'd1,
    PH_ONE  = 2'd2
  } qpd_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } qpd_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       malformed;
    logic       stream_end;
  } qpd_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } qpd_hex_t;

  function automatic qpd_hex_t hex_value(input logic [7:0] c);
    qpd_hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h57);
    end
    return h;
  endfunction

  function automatic logic [7:0] bad_value(input logic [7:0] c);
    qpd_hex_t h;
    h = hex_value(c);
    return h.ok ? {4'd0, h.val} : 8'd0;
  endfunction

endpackage

### rtl/quoted_printable_decoder.sv
// Top level of the quoted-printable decoder.
// The source channel delivers one encoded byte per beat on in_byte_i, with
// in_last_i marking the final byte of a string. A beat is taken at a rising
// edge where in_valid_i is high and in_stall_o is low.
// The result channel gives at most one decoded byte per source beat, with
// has_byte_o, malformed_o and stream_end_o. The last source beat always
// gives a result beat, even when no byte comes out of it.
// A taken beat sits in the input register, and its result is loaded into the
// result register once that register is ready, where it waits until the
// receiver takes it.
// One source beat is taken every cycle while the receiver does not stall; the
// decode between the two registers is combinational.
// Beats that produce no result leave the input register without waiting.
// When the receiver stalls, the result register holds its beat, one more
// source beat waits in the input register, and then in_stall_o rises.
// Reset clears the valid flags of both registers and returns the escape state to idle.
module quoted_printable_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       malformed_o,
  output logic       stream_end_o
);

  logic                 item_valid;
  qpd_pkg::qpd_item_t   item;
  logic                 emit;
  qpd_pkg::qpd_result_t result;
  qpd_pkg::qpd_result_t out_result;
  logic                 out_ready;
  logic                 advance;
  logic                 load;

  assign advance = item_valid && (out_ready || !emit);
  assign load    = item_valid && emit && out_ready;

  qpd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .in_stall_o   (in_stall_o),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  qpd_decode_core u_decode_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .advance_i (advance),
    .emit_o    (emit),
    .result_o  (result)
  );

  qpd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .result_i    (result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign out_byte_o   = out_result.out_byte;
  assign has_byte_o   = out_result.has_byte;
  assign malformed_o  = out_result.malformed;
  assign stream_end_o = out_result.stream_end;

  a_malformed_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && malformed_o |-> has_byte_o)
    else $error("Malformed beat without a decoded byte.");

  a_empty_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> stream_end_o && out_byte_o == 8'd0)
    else $error("Empty result beat that is not a clean end of stream.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item_valid && out_valid_o && out_stall_i)
    else $error("Source stalled while the pipeline could move.");

endmodule

### rtl/qpd_in_stage.sv
// Input register stage that captures one source beat.
module qpd_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  output logic                in_stall_o,
  input  logic                advance_i,
  output logic                item_valid_o,
  output qpd_pkg::qpd_item_t  item_o
);

  logic               valid_q, valid_d;
  qpd_pkg::qpd_item_t item_q;
  logic               accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data <= in_byte_i;
      item_q.last <= in_last_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### rtl/qpd_decode_core.sv
// Escape state machine and per-beat decode logic.
module qpd_decode_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qpd_pkg::qpd_item_t   item_i,
  input  logic                 advance_i,
  output logic                 emit_o,
  output qpd_pkg::qpd_result_t result_o
);

  qpd_pkg::qpd_phase_e phase_q, phase_d;
  logic [7:0]          held_q, held_d;
  logic                has, bad;
  logic [7:0]          val;
  qpd_pkg::qpd_hex_t   hi, lo;

  assign hi = qpd_pkg::hex_value(held_q);
  assign lo = qpd_pkg::hex_value(item_i.data);

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    has     = 1'b0;
    bad     = 1'b0;
    val     = 8'd0;
    unique case (phase_q)
      qpd_pkg::PH_EQ: begin
        if (item_i.data == qpd_pkg::CH_LF) begin
          phase_d = qpd_pkg::PH_IDLE;
        end else if (item_i.data == qpd_pkg::CH_EQ) begin
          phase_d = qpd_pkg::PH_EQ;
        end else begin
          held_d  = item_i.data;
          phase_d = qpd_pkg::PH_ONE;
        end
      end
      qpd_pkg::PH_ONE: begin
        phase_d = qpd_pkg::PH_IDLE;
        if (held_q == qpd_pkg::CH_CR && item_i.data == qpd_pkg::CH_LF) begin
          has = 1'b0;
        end else if (hi.ok && lo.ok) begin
          has = 1'b1;
          val = {hi.val, lo.val};
        end else begin
          has = 1'b1;
          bad = 1'b1;
          val = qpd_pkg::bad_value(held_q);
        end
      end
      default: begin
        if (item_i.data == qpd_pkg::CH_EQ) begin
          phase_d = qpd_pkg::PH_EQ;
        end else begin
          phase_d = qpd_pkg::PH_IDLE;
          has     = 1'b1;
          val     = item_i.data;
        end
      end
    endcase

    if (item_i.last) begin
      if (phase_d == qpd_pkg::PH_EQ) begin
        has = 1'b1;
        bad = 1'b1;
        val = 8'd0;
      end else if (phase_d == qpd_pkg::PH_ONE) begin
        has = 1'b1;
        bad = 1'b1;
        val = qpd_pkg::bad_value(held_d);
      end
      phase_d = qpd_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= qpd_pkg::PH_IDLE;
      held_q  <= 8'd0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  assign emit_o              = has || item_i.last;
  assign result_o.out_byte   = has ? val : 8'd0;
  assign result_o.has_byte   = has;
  assign result_o.malformed  = has && bad;
  assign result_o.stream_end = item_i.last;

endmodule

### rtl/qpd_out_stage.sv
// Result register that holds one decoded beat until the receiver takes it.
module qpd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  qpd_pkg::qpd_result_t result_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output qpd_pkg::qpd_result_t result_o
);

  logic                 valid_q, valid_d;
  qpd_pkg::qpd_result_t result_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

### verif/tb_quoted_printable_decoder.sv
// Self-checking testbench for the quoted-printable decoder with a built-in decode predictor.
`timescale 1ns / 1ps

module tb_quoted_printable_decoder;

  typedef struct packed {
    logic [7:0]           ch;
    logic                 last;
    logic                 pinned;
    logic                 produces;
    qpd_pkg::qpd_result_t want;
  } qpd_row_t;

  localparam int RowCount = 28;
  localparam qpd_row_t DIRECTED [RowCount] = '{
    '{8'h00,          1'b0, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{8'hFF,          1'b0, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
    '{qpd_pkg::CH_EQ, 1'b0, 1'b0, 1'b0, '0},
    '{"f",            1'b0, 1'b0, 1'b0, '0},
    '{"A",            1'b0, 1'b0, 1'b0, '0},
    '{qpd_pkg::CH_EQ, 1'b0, 1'b0, 1'b0, '0},
    '{qpd_pkg::CH_CR, 1'b0, 1'b0, 1'b0, '0},
    '{qpd_pkg::CH_LF, 1'b0, 1'b0, 1'b0, '0},
    '{qpd_pkg::CH_EQ, 1'b0, 1'b0, 1'b0, '0},
    '{qpd_pkg::CH_EQ, 1'b0, 1'b0, 1'b0, '0},
    '{"G",            1'b0, 1'b0, 1'b0, '0},
    '{"1",            1'b0, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{qpd_pkg::CH_EQ, 1'b0, 1'b0, 1'b0, '0},
    '{qpd_pkg::CH_LF, 1'b0, 1'b0, 1'b0, '0},
    '{qpd_pkg::CH_EQ, 1'b0, 1'b0, 1'b0, '0},
    '{qpd_pkg::CH_CR, 1'b0, 1'b0, 1'b0, '0},
    '{"X",            1'b0, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{qpd_pkg::CH_EQ, 1'b0, 1'b0, 1'b0, '0},
    '{"9",            1'b0, 1'b0, 1'b0, '0},
    '{qpd_pkg::CH_EQ, 1'b0, 1'b1, 1'b1, '{8'h09, 1'b1, 1'b1, 1'b0}},
    '{qpd_pkg::CH_EQ, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}},
    '{qpd_pkg::CH_EQ, 1'b0, 1'b0, 1'b0, '0},
    '{"c",            1'b1, 1'b1, 1'b1, '{8'h0C, 1'b1, 1'b1, 1'b1}},
    '{qpd_pkg::CH_EQ, 1'b0, 1'b0, 1'b0, '0},
    '{qpd_pkg::CH_LF, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
    '{qpd_pkg::CH_EQ, 1'b0, 1'b0, 1'b0, '0},
    '{qpd_pkg::CH_CR, 1'b0, 1'b0, 1'b0, '0},
    '{qpd_pkg::CH_LF, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}}
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i   = 8'h00;
  logic       in_last_i   = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       has_byte_o;
  logic       malformed_o;
  logic       stream_end_o;

  qpd_pkg::qpd_phase_e  esc_phase = qpd_pkg::PH_IDLE;
  logic [7:0]           esc_held  = 8'h00;
  qpd_pkg::qpd_result_t decoded_q [$];
  int                   mismatches = 0;
  int                   beats_sent = 0;
  logic                 steady     = 1'b0;

  quoted_printable_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .malformed_o (malformed_o),
    .stream_end_o(stream_end_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = c[3:0] + 4'd9;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic decode_beat(input logic [7:0] b, input logic last,
                                       output qpd_pkg::qpd_result_t r);
    logic [3:0] hi, lo;
    logic       hi_ok, lo_ok;
    r = '0;
    case (esc_phase)
      qpd_pkg::PH_EQ: begin
        if (b == qpd_pkg::CH_LF) begin
          esc_phase = qpd_pkg::PH_IDLE;
        end else if (b != qpd_pkg::CH_EQ) begin
          esc_held  = b;
          esc_phase = qpd_pkg::PH_ONE;
        end
      end
      qpd_pkg::PH_ONE: begin
        hi_ok = hex_nibble(esc_held, hi);
        lo_ok = hex_nibble(b, lo);
        esc_phase = qpd_pkg::PH_IDLE;
        if (!(esc_held == qpd_pkg::CH_CR && b == qpd_pkg::CH_LF)) begin
          r.has_byte  = 1'b1;
          r.malformed = !(hi_ok && lo_ok);
          r.out_byte  = (hi_ok && lo_ok) ? {hi, lo} : {4'd0, hi};
        end
      end
      default: begin
        if (b == qpd_pkg::CH_EQ) begin
          esc_phase = qpd_pkg::PH_EQ;
        end else begin
          esc_phase  = qpd_pkg::PH_IDLE;
          r.has_byte = 1'b1;
          r.out_byte = b;
        end
      end
    endcase
    if (last) begin
      if (esc_phase == qpd_pkg::PH_EQ) begin
        r.has_byte  = 1'b1;
        r.malformed = 1'b1;
        r.out_byte  = 8'h00;
      end else if (esc_phase == qpd_pkg::PH_ONE) begin
        hi_ok = hex_nibble(esc_held, hi);
        r.has_byte  = 1'b1;
        r.malformed = 1'b1;
        r.out_byte  = {4'd0, hi};
      end
      esc_phase    = qpd_pkg::PH_IDLE;
      r.stream_end = 1'b1;
    end
    return r.has_byte || last;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic last,
                           output qpd_pkg::qpd_result_t r, output logic produced);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_byte_i  <= b;
    in_last_i  <= last;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    produced = decode_beat(b, last, r);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == qpd_pkg::CH_EQ);
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    int unsigned v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'h30 + 8'(v);
    if (v < 16) return 8'h37 + 8'(v);
    return 8'h51 + 8'(v);
  endfunction

  task automatic send_random_stream();
    logic [7:0]           seq [$];
    int unsigned          kind;
    qpd_pkg::qpd_result_t r;
    logic                 produced;
    repeat ($urandom_range(1, 8)) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        seq.push_back(plain_char());
      end else if (kind < 65) begin
        seq.push_back(qpd_pkg::CH_EQ);
        seq.push_back(hex_char());
        seq.push_back(hex_char());
      end else if (kind < 73) begin
        seq.push_back(qpd_pkg::CH_EQ);
        seq.push_back(qpd_pkg::CH_CR);
        seq.push_back(qpd_pkg::CH_LF);
      end else if (kind < 78) begin
        seq.push_back(qpd_pkg::CH_EQ);
        seq.push_back(qpd_pkg::CH_EQ);
        seq.push_back(hex_char());
        seq.push_back(hex_char());
      end else if (kind < 83) begin
        seq.push_back(qpd_pkg::CH_EQ);
        seq.push_back(qpd_pkg::CH_LF);
      end else if (kind < 88) begin
        seq.push_back(qpd_pkg::CH_EQ);
        seq.push_back(qpd_pkg::CH_CR);
        seq.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 94) begin
        seq.push_back(qpd_pkg::CH_EQ);
        seq.push_back(8'($urandom_range(0, 255)));
        seq.push_back(8'($urandom_range(0, 255)));
      end else begin
        seq.push_back(8'($urandom_range(0, 255)));
      end
    end
    // Now and then one or two bytes are cut from the end, which can end the stream inside an escape.
    if (seq.size() > 2 && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 2)) void'(seq.pop_back());
    end
    foreach (seq[i]) begin
      send_beat(seq[i], i == seq.size() - 1, r, produced);
      if (produced) decoded_q.push_back(r);
    end
  endtask

  always @(posedge clk_i) begin
    qpd_pkg::qpd_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        $error("result beat arrived with no result expected");
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (out_byte_o !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, out_byte_o);
          mismatches++;
        end
        if (has_byte_o !== want.has_byte) begin
          $error("has_byte: expected %b, actual %b", want.has_byte, has_byte_o);
          mismatches++;
        end
        if (malformed_o !== want.malformed) begin
          $error("malformed: expected %b, actual %b", want.malformed, malformed_o);
          mismatches++;
        end
        if (stream_end_o !== want.stream_end) begin
          $error("stream_end: expected %b, actual %b", want.stream_end, stream_end_o);
          mismatches++;
        end
      end
    end
    out_stall_i <= !steady && ($urandom_range(0, 99) < 31);
  end

  initial begin
    #400us;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    qpd_pkg::qpd_result_t r;
    logic                 produced;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (DIRECTED[i]) begin
      send_beat(DIRECTED[i].ch, DIRECTED[i].last, r, produced);
      if (DIRECTED[i].pinned) begin
        if (DIRECTED[i].produces) decoded_q.push_back(DIRECTED[i].want);
      end else if (produced) begin
        decoded_q.push_back(r);
      end
    end
    while (beats_sent < RowCount + 650) begin
      steady = (beats_sent >= 250 && beats_sent < 400);
      send_random_stream();
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
